// File: rtl/lmtc_pkg.sv
// Shared types and constants for the LCD mode timing controller.
package lmtc_pkg;

  localparam int unsigned NUM_REGS = 12;

  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [7:0] TOTAL_LINES   = 8'd154;

  localparam logic [7:0] STAT_WRITABLE = 8'b0111_1000;
  localparam logic [7:0] STAT_KEPT     = 8'b1000_0111;

  // Transaction kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // PPU modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Register offsets
  localparam logic [3:0] REG_LCDC = 4'd0;
  localparam logic [3:0] REG_STAT = 4'd1;
  localparam logic [3:0] REG_LY   = 4'd4;
  localparam logic [3:0] REG_LYC  = 4'd5;
  localparam logic [3:0] REG_DMA  = 4'd6;
  localparam logic [3:0] REG_LAST = 4'd11;

  // Configuration register indexes
  localparam logic [1:0] CFG_OAM_SCAN    = 2'd0;
  localparam logic [1:0] CFG_TRANSFER    = 2'd1;
  localparam logic [1:0] CFG_HBLANK      = 2'd2;
  localparam logic [1:0] CFG_VBLANK_LINE = 2'd3;

  localparam logic [9:0] OAM_SCAN_RESET    = 10'd80;
  localparam logic [9:0] TRANSFER_RESET    = 10'd172;
  localparam logic [9:0] HBLANK_RESET      = 10'd204;
  localparam logic [9:0] VBLANK_LINE_RESET = 10'd456;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] cycles;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] status_byte;
    logic [7:0] line_number;
    logic [1:0] ppu_mode;
    logic       vblank_irq;
    logic       stat_irq;
    logic       render_line;
    logic       frame_done;
    logic       dma_strobe;
    logic [7:0] dma_page;
  } result_t;

  typedef struct packed {
    logic [9:0] oam_scan_cycles;
    logic [9:0] transfer_cycles;
    logic [9:0] hblank_cycles;
    logic [9:0] vblank_line_cycles;
  } cfg_t;

  typedef struct packed {
    logic [NUM_REGS-1:0][7:0] regs;
    logic [1:0]               cur_mode;
    logic [15:0]              cycle_count;
    logic [1:0]               prior_mode;
    logic [7:0]               prior_line;
  } state_t;

endpackage

// File: rtl/lcd_mode_timing_controller_top.sv
// Top level of the LCD mode timing controller: handshake, state and config registers.
//
// One transaction (tick, register read or register write) is accepted per clock: the
// transaction is captured in an input register, the single-pass update logic computes the
// new mode, line, STAT and interrupt flags, and the result lands in an output register
// together with the state update. Sustained rate is one transaction per cycle whenever
// result_ready is high. Configuration writes through cfg_we take effect at the next clock
// and are meant for idle periods only.
module lcd_mode_timing_controller_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  lmtc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output lmtc_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_data
);

  lmtc_pkg::item_t   item_q;
  logic              item_full;
  lmtc_pkg::result_t result_q;
  logic              result_full;
  lmtc_pkg::state_t  state;
  lmtc_pkg::state_t  state_next;
  lmtc_pkg::result_t result_next;
  lmtc_pkg::cfg_t    cfg;
  lmtc_pkg::state_t  state_reset;
  logic              fire;

  assign fire         = item_full && (!result_full || result_ready);
  assign item_ready   = !item_full || fire;
  assign result_valid = result_full;
  assign result       = result_q;

  always_comb begin
    state_reset = '0;
    state_reset.regs[lmtc_pkg::REG_STAT] = {6'd0, lmtc_pkg::MODE_OAM};
    state_reset.cur_mode   = lmtc_pkg::MODE_OAM;
    state_reset.prior_mode = lmtc_pkg::MODE_OAM;
  end

  lmtc_step u_step (
    .state_cur  (state),
    .cfg        (cfg),
    .item       (item_q),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
    if (fire) begin
      result_q <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full   <= 1'b0;
      result_full <= 1'b0;
      state       <= state_reset;
    end else begin
      if (item_valid && item_ready) begin
        item_full <= 1'b1;
      end else if (fire) begin
        item_full <= 1'b0;
      end
      if (fire) begin
        result_full <= 1'b1;
        state       <= state_next;
      end else if (result_ready) begin
        result_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.oam_scan_cycles    <= lmtc_pkg::OAM_SCAN_RESET;
      cfg.transfer_cycles    <= lmtc_pkg::TRANSFER_RESET;
      cfg.hblank_cycles      <= lmtc_pkg::HBLANK_RESET;
      cfg.vblank_line_cycles <= lmtc_pkg::VBLANK_LINE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmtc_pkg::CFG_OAM_SCAN:    cfg.oam_scan_cycles    <= cfg_data;
        lmtc_pkg::CFG_TRANSFER:    cfg.transfer_cycles    <= cfg_data;
        lmtc_pkg::CFG_HBLANK:      cfg.hblank_cycles      <= cfg_data;
        lmtc_pkg::CFG_VBLANK_LINE: cfg.vblank_line_cycles <= cfg_data;
        default:                   cfg.vblank_line_cycles <= cfg_data;
      endcase
    end
  end

endmodule

// File: rtl/lmtc_step.sv
// Next-state and result logic for one transaction.
module lmtc_step (
  input  lmtc_pkg::state_t  state_cur,
  input  lmtc_pkg::cfg_t    cfg,
  input  lmtc_pkg::item_t   item,
  output lmtc_pkg::state_t  state_next,
  output lmtc_pkg::result_t result
);

  logic [7:0]  stat;
  logic [7:0]  ly;
  logic [7:0]  lyc;
  logic [7:0]  line_inc;
  logic [15:0] cnt_sum;
  logic [9:0]  thr;

  assign stat     = state_cur.regs[lmtc_pkg::REG_STAT];
  assign ly       = state_cur.regs[lmtc_pkg::REG_LY];
  assign lyc      = state_cur.regs[lmtc_pkg::REG_LYC];
  assign line_inc = ly + 8'd1;
  assign cnt_sum  = state_cur.cycle_count + {8'd0, item.cycles};

  always_comb begin
    unique case (state_cur.cur_mode)
      lmtc_pkg::MODE_OAM:    thr = cfg.oam_scan_cycles;
      lmtc_pkg::MODE_XFER:   thr = cfg.transfer_cycles;
      lmtc_pkg::MODE_HBLANK: thr = cfg.hblank_cycles;
      default:               thr = cfg.vblank_line_cycles;
    endcase
  end

  always_comb begin
    lmtc_pkg::state_t nxt;
    logic [7:0] stat_new;
    logic       lyc_chk;
    logic       req_stat;
    logic       req_vblank;
    logic       render;
    logic       frame;
    logic       dma;
    logic [7:0] page;
    logic [7:0] rd;

    nxt        = state_cur;
    lyc_chk    = 1'b0;
    req_stat   = 1'b0;
    req_vblank = 1'b0;
    render     = 1'b0;
    frame      = 1'b0;
    dma        = 1'b0;
    page       = 8'd0;
    rd         = 8'd0;

    unique case (item.mode)
      lmtc_pkg::KIND_TICK: begin
        if (state_cur.regs[lmtc_pkg::REG_LCDC][7]) begin
          nxt.prior_mode  = state_cur.cur_mode;
          nxt.prior_line  = ly;
          nxt.cycle_count = cnt_sum;
          if (cnt_sum >= {6'd0, thr}) begin
            nxt.cycle_count = cnt_sum - {6'd0, thr};
            unique case (state_cur.cur_mode)
              lmtc_pkg::MODE_OAM: begin
                nxt.cur_mode = lmtc_pkg::MODE_XFER;
              end
              lmtc_pkg::MODE_XFER: begin
                nxt.cur_mode = lmtc_pkg::MODE_HBLANK;
                render       = 1'b1;
                if (stat[3]) req_stat = 1'b1;
              end
              lmtc_pkg::MODE_HBLANK: begin
                nxt.regs[lmtc_pkg::REG_LY] = line_inc;
                lyc_chk = 1'b1;
                if (line_inc == lyc && stat[6]) req_stat = 1'b1;
                if (line_inc == lmtc_pkg::VISIBLE_LINES) begin
                  nxt.cur_mode = lmtc_pkg::MODE_VBLANK;
                  frame        = 1'b1;
                  req_vblank   = 1'b1;
                  if (stat[4]) req_stat = 1'b1;
                end else begin
                  nxt.cur_mode = lmtc_pkg::MODE_OAM;
                  if (stat[5]) req_stat = 1'b1;
                end
              end
              default: begin
                lyc_chk = 1'b1;
                if (line_inc == lyc && stat[6]) req_stat = 1'b1;
                if (line_inc >= lmtc_pkg::TOTAL_LINES) begin
                  nxt.regs[lmtc_pkg::REG_LY] = 8'd0;
                  nxt.cur_mode = lmtc_pkg::MODE_OAM;
                  if (lyc == 8'd0 && stat[6]) req_stat = 1'b1;
                  if (stat[5]) req_stat = 1'b1;
                end else begin
                  nxt.regs[lmtc_pkg::REG_LY] = line_inc;
                end
              end
            endcase
          end
        end
      end
      lmtc_pkg::KIND_READ: begin
        if (item.reg_offset <= lmtc_pkg::REG_LAST) begin
          rd = state_cur.regs[item.reg_offset];
        end
      end
      lmtc_pkg::KIND_WRITE: begin
        if (item.reg_offset <= lmtc_pkg::REG_LAST) begin
          unique case (item.reg_offset)
            lmtc_pkg::REG_LY: begin
            end
            lmtc_pkg::REG_LYC: begin
              nxt.regs[lmtc_pkg::REG_LYC] = item.write_data;
              lyc_chk = 1'b1;
              if (ly == item.write_data && stat[6]) req_stat = 1'b1;
            end
            lmtc_pkg::REG_DMA: begin
              dma  = 1'b1;
              page = item.write_data;
            end
            lmtc_pkg::REG_STAT: begin
              nxt.regs[lmtc_pkg::REG_STAT] = (item.write_data & lmtc_pkg::STAT_WRITABLE)
                                             | (stat & lmtc_pkg::STAT_KEPT);
            end
            lmtc_pkg::REG_LCDC: begin
              if (state_cur.regs[lmtc_pkg::REG_LCDC][7] && !item.write_data[7]) begin
                // disable: interrupt check still sees the LCD as on
                nxt.regs[lmtc_pkg::REG_LY] = 8'd0;
                nxt.cycle_count = 16'd0;
                nxt.cur_mode    = lmtc_pkg::MODE_HBLANK;
                lyc_chk = 1'b1;
                if (lyc == 8'd0 && stat[6]) req_stat = 1'b1;
                if (state_cur.prior_mode != lmtc_pkg::MODE_HBLANK && stat[3]) req_stat = 1'b1;
              end else if (!state_cur.regs[lmtc_pkg::REG_LCDC][7] && item.write_data[7]) begin
                nxt.regs[lmtc_pkg::REG_LY] = 8'd0;
                nxt.cycle_count = 16'd0;
                nxt.cur_mode    = lmtc_pkg::MODE_OAM;
                lyc_chk = 1'b1;
                if (lyc == 8'd0 && stat[6]) req_stat = 1'b1;
              end
              nxt.regs[lmtc_pkg::REG_LCDC] = item.write_data;
            end
            default: begin
              nxt.regs[item.reg_offset] = item.write_data;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    stat_new      = nxt.regs[lmtc_pkg::REG_STAT];
    stat_new[1:0] = nxt.cur_mode;
    if (lyc_chk) begin
      stat_new[2] = (nxt.regs[lmtc_pkg::REG_LY] == nxt.regs[lmtc_pkg::REG_LYC]);
    end
    nxt.regs[lmtc_pkg::REG_STAT] = stat_new;

    state_next         = nxt;
    result.read_data   = rd;
    result.status_byte = stat_new;
    result.line_number = nxt.regs[lmtc_pkg::REG_LY];
    result.ppu_mode    = nxt.cur_mode;
    result.vblank_irq  = req_vblank;
    result.stat_irq    = req_stat;
    result.render_line = render;
    result.frame_done  = frame;
    result.dma_strobe  = dma;
    result.dma_page    = page;
  end

endmodule
